// ===== sv/kpad_pkg.sv =====
// ----------------------------------------------------------------------------
// kpad_pkg: shared types and constants for the keypoint anchor decoder
// request and response payloads, anchor walk tag, register map and
// fixed arithmetic widths
// ----------------------------------------------------------------------------
package kpad_pkg;

   // anchor layout
   localparam int CORNER_VALUES       = 8;
   localparam int OBJECTNESS_POSITION = 8;
   localparam int HEAD_VALUES         = 9;

   // tag field widths, sized for the largest supported grid and score counts
   localparam int SLOT_W          = 4;
   localparam int GRID_W          = 8;
   localparam int ANCHOR_NUMBER_W = 12;
   localparam int INDEX_W         = 3;

   // corner arithmetic
   localparam int VALUE_W  = 32;
   localparam int SCALE_W  = 24;
   localparam int SUM_W    = 33;
   localparam int PRE_W    = 38;
   localparam int SPLIT_W  = 19;
   localparam int LO_PROD_W = SPLIT_W + SCALE_W;
   localparam int HI_PROD_W = (PRE_W - SPLIT_W) + SCALE_W + 1;
   localparam int FULL_W   = PRE_W + SCALE_W + 1;
   localparam int SCALED_W = FULL_W - 16;
   localparam int TOTAL_W  = SCALED_W + 1;

   localparam logic [VALUE_W-1:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [VALUE_W-1:0] SAT_MIN = 32'h8000_0000;

   // register map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [SCALE_W-1:0] INVERSE_SCALE_RESET   = 24'd65536;
   localparam logic [VALUE_W-1:0] OFFSET_X_RESET        = 32'd0;
   localparam logic [VALUE_W-1:0] OFFSET_Y_RESET        = 32'd0;
   localparam logic [VALUE_W-1:0] SCORE_THRESHOLD_RESET = 32'd55706;

   typedef enum logic [1:0] {
      REG_INVERSE_SCALE,
      REG_OFFSET_X,
      REG_OFFSET_Y,
      REG_SCORE_THRESHOLD
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_CORNER,
      KIND_OBJECTNESS,
      KIND_COLOR,
      KIND_CLASS
   } kind_type;

   typedef enum logic [1:0] {
      LEVEL_S8,
      LEVEL_S16,
      LEVEL_S32
   } level_type;

   typedef struct packed {
      kind_type                   kind;
      logic [SLOT_W-1:0]          slot;
      logic                       is_y;
      logic                       last;
      logic [GRID_W-1:0]          grid;
      level_type                  level;
      logic [ANCHOR_NUMBER_W-1:0] anchor;
   } tag_type;

   typedef struct packed {
      logic [INDEX_W-1:0]        color_index;
      logic [INDEX_W-1:0]        class_index;
      logic signed [VALUE_W-1:0] objectness;
   } score_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] feature_value;
      logic                      frame_start;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  corner0_x;
      logic signed [VALUE_W-1:0]  corner0_y;
      logic signed [VALUE_W-1:0]  corner1_x;
      logic signed [VALUE_W-1:0]  corner1_y;
      logic signed [VALUE_W-1:0]  corner2_x;
      logic signed [VALUE_W-1:0]  corner2_y;
      logic signed [VALUE_W-1:0]  corner3_x;
      logic signed [VALUE_W-1:0]  corner3_y;
      logic [INDEX_W-1:0]         color_index;
      logic [INDEX_W-1:0]         class_index;
      logic signed [VALUE_W-1:0]  objectness;
      logic [ANCHOR_NUMBER_W-1:0] anchor_number;
   } rsp_type;

endpackage

// ===== sv/kpad_walk.sv =====
// ----------------------------------------------------------------------------
// kpad_walk: anchor walk counters
// tracks the value position within an anchor and the grid cell and stride
// level of the anchor, and tags each accepted request
// ----------------------------------------------------------------------------
module kpad_walk
   import kpad_pkg::*;
#(
   parameter int IMAGE_WIDTH  = 416,
   parameter int IMAGE_HEIGHT = 416,
   parameter int COLOR_COUNT  = 8,
   parameter int CLASS_COUNT  = 8
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  logic    frame_start,
   output tag_type tag
);

   localparam int VALUES   = HEAD_VALUES + COLOR_COUNT + CLASS_COUNT;
   localparam int POS_W    = $clog2(VALUES);
   localparam int COLS0    = IMAGE_WIDTH / 8;
   localparam int COLS1    = IMAGE_WIDTH / 16;
   localparam int COLS2    = IMAGE_WIDTH / 32;
   localparam int ROWS0    = IMAGE_HEIGHT / 8;
   localparam int ROWS1    = IMAGE_HEIGHT / 16;
   localparam int ROWS2    = IMAGE_HEIGHT / 32;
   localparam int COL_W    = $clog2(COLS0);
   localparam int ROW_W    = $clog2(ROWS0);
   localparam int TOTAL    = COLS0 * ROWS0 + COLS1 * ROWS1 + COLS2 * ROWS2;
   localparam int ANCHOR_W = $clog2(TOTAL);

   logic [POS_W-1:0]    pos_ff, pos_in, pos_cur;
   logic [COL_W-1:0]    col_ff, col_in, col_cur, col_end;
   logic [ROW_W-1:0]    row_ff, row_in, row_cur, row_end;
   logic [ANCHOR_W-1:0] anchor_ff, anchor_in, anchor_cur;
   level_type           level_ff, level_in, level_cur, level_next;

   assign pos_cur    = frame_start ? '0 : pos_ff;
   assign col_cur    = frame_start ? '0 : col_ff;
   assign row_cur    = frame_start ? '0 : row_ff;
   assign anchor_cur = frame_start ? '0 : anchor_ff;
   assign level_cur  = frame_start ? LEVEL_S8 : level_ff;

   always_comb begin
      case (level_cur)
         LEVEL_S8: begin
            col_end    = COL_W'(COLS0 - 1);
            row_end    = ROW_W'(ROWS0 - 1);
            level_next = LEVEL_S16;
         end
         LEVEL_S16: begin
            col_end    = COL_W'(COLS1 - 1);
            row_end    = ROW_W'(ROWS1 - 1);
            level_next = LEVEL_S32;
         end
         LEVEL_S32: begin
            col_end    = COL_W'(COLS2 - 1);
            row_end    = ROW_W'(ROWS2 - 1);
            level_next = LEVEL_S8;
         end
         default: begin
            col_end    = COL_W'(COLS0 - 1);
            row_end    = ROW_W'(ROWS0 - 1);
            level_next = LEVEL_S8;
         end
      endcase
   end

   // request tag
   always_comb begin
      tag        = '0;
      tag.anchor = ANCHOR_NUMBER_W'(anchor_cur);
      tag.level  = level_cur;
      tag.last   = (pos_cur == POS_W'(VALUES - 1));
      tag.is_y   = pos_cur[0];
      tag.grid   = pos_cur[0] ? GRID_W'(row_cur) : GRID_W'(col_cur);
      if (pos_cur < POS_W'(CORNER_VALUES)) begin
         tag.kind = KIND_CORNER;
         tag.slot = SLOT_W'(pos_cur);
      end else if (pos_cur == POS_W'(OBJECTNESS_POSITION)) begin
         tag.kind = KIND_OBJECTNESS;
      end else if (pos_cur < POS_W'(HEAD_VALUES + COLOR_COUNT)) begin
         tag.kind = KIND_COLOR;
         tag.slot = SLOT_W'(pos_cur - POS_W'(HEAD_VALUES));
      end else begin
         tag.kind = KIND_CLASS;
         tag.slot = SLOT_W'(pos_cur - POS_W'(HEAD_VALUES + COLOR_COUNT));
      end
   end

   // walk advance
   always_comb begin
      pos_in    = pos_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      anchor_in = anchor_ff;
      level_in  = level_ff;
      if (accept) begin
         pos_in    = pos_cur + POS_W'(1);
         col_in    = col_cur;
         row_in    = row_cur;
         anchor_in = anchor_cur;
         level_in  = level_cur;
         if (tag.last) begin
            pos_in    = '0;
            anchor_in = anchor_cur + ANCHOR_W'(1);
            col_in    = col_cur + COL_W'(1);
            if (col_cur == col_end) begin
               col_in = '0;
               row_in = row_cur + ROW_W'(1);
               if (row_cur == row_end) begin
                  row_in   = '0;
                  level_in = level_next;
                  if (level_cur == LEVEL_S32) begin
                     anchor_in = '0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         anchor_ff <= '0;
         level_ff  <= LEVEL_S8;
      end else begin
         pos_ff    <= pos_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         anchor_ff <= anchor_in;
         level_ff  <= level_in;
      end
   end

endmodule

// ===== sv/kpad_corner.sv =====
// ----------------------------------------------------------------------------
// kpad_corner: corner coordinate decode pipeline
// adds the grid cell, shifts by the stride, multiplies by the inverse scale
// in two partial products, floors, adds the offset and saturates
// ----------------------------------------------------------------------------
module kpad_corner
   import kpad_pkg::*;
(
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          load,
   input  logic signed [VALUE_W-1:0]                     value,
   input  tag_type                                       tag,
   input  logic [SCALE_W-1:0]                            inverse_scale,
   input  logic signed [VALUE_W-1:0]                     offset_x,
   input  logic signed [VALUE_W-1:0]                     offset_y,
   output logic [CORNER_VALUES-1:0][VALUE_W-1:0]         corners
);

   logic signed [SUM_W-1:0]    grid_sum;

   logic                       s1_valid_ff, s1_valid_in;
   logic signed [PRE_W-1:0]    s1_pre_ff, s1_pre_in;
   logic [2:0]                 s1_slot_ff, s1_slot_in;
   logic                       s1_is_y_ff, s1_is_y_in;

   logic                       s2_valid_ff, s2_valid_in;
   logic [LO_PROD_W-1:0]       s2_lo_ff, s2_lo_in;
   logic signed [HI_PROD_W-1:0] s2_hi_ff, s2_hi_in;
   logic [2:0]                 s2_slot_ff, s2_slot_in;
   logic                       s2_is_y_ff, s2_is_y_in;

   logic                       s3_valid_ff, s3_valid_in;
   logic signed [SCALED_W-1:0] s3_scaled_ff, s3_scaled_in;
   logic [2:0]                 s3_slot_ff, s3_slot_in;
   logic                       s3_is_y_ff, s3_is_y_in;

   logic [FULL_W-1:0]          full_sum;
   logic [VALUE_W-1:0]         offset;
   logic [TOTAL_W-1:0]         total;
   logic [VALUE_W-1:0]         coord_in;
   logic [CORNER_VALUES-1:0][VALUE_W-1:0] corner_ff;

   // stage 1: grid add and stride shift
   assign grid_sum = {value[VALUE_W-1], value} + {9'b0, tag.grid, 16'b0};

   always_comb begin
      case (tag.level)
         LEVEL_S8:  s1_pre_in = {{2{grid_sum[SUM_W-1]}}, grid_sum, 3'b000};
         LEVEL_S16: s1_pre_in = {grid_sum[SUM_W-1], grid_sum, 4'b0000};
         LEVEL_S32: s1_pre_in = {grid_sum, 5'b00000};
         default:   s1_pre_in = '0;
      endcase
   end

   assign s1_valid_in = load;
   assign s1_slot_in  = tag.slot[2:0];
   assign s1_is_y_in  = tag.is_y;

   // stage 2: partial products
   assign s2_valid_in = s1_valid_ff;
   assign s2_lo_in    = s1_pre_ff[SPLIT_W-1:0] * inverse_scale;
   assign s2_hi_in    = $signed(s1_pre_ff[PRE_W-1:SPLIT_W]) * $signed({1'b0, inverse_scale});
   assign s2_slot_in  = s1_slot_ff;
   assign s2_is_y_in  = s1_is_y_ff;

   // stage 3: combine and floor
   assign full_sum     = {s2_hi_ff, {SPLIT_W{1'b0}}} + {{(FULL_W - LO_PROD_W){1'b0}}, s2_lo_ff};
   assign s3_scaled_in = full_sum[FULL_W-1:16];
   assign s3_valid_in  = s2_valid_ff;
   assign s3_slot_in   = s2_slot_ff;
   assign s3_is_y_in   = s2_is_y_ff;

   // stage 4: offset and saturation
   assign offset = s3_is_y_ff ? offset_y : offset_x;
   assign total  = {s3_scaled_ff[SCALED_W-1], s3_scaled_ff}
                 + {{(TOTAL_W - VALUE_W){offset[VALUE_W-1]}}, offset};

   always_comb begin
      if (total[TOTAL_W-1:VALUE_W-1] == {(TOTAL_W - VALUE_W + 1){total[TOTAL_W-1]}}) begin
         coord_in = total[VALUE_W-1:0];
      end else if (total[TOTAL_W-1]) begin
         coord_in = SAT_MIN;
      end else begin
         coord_in = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pre_ff    <= s1_pre_in;
      s1_slot_ff   <= s1_slot_in;
      s1_is_y_ff   <= s1_is_y_in;
      s2_lo_ff     <= s2_lo_in;
      s2_hi_ff     <= s2_hi_in;
      s2_slot_ff   <= s2_slot_in;
      s2_is_y_ff   <= s2_is_y_in;
      s3_scaled_ff <= s3_scaled_in;
      s3_slot_ff   <= s3_slot_in;
      s3_is_y_ff   <= s3_is_y_in;
      if (s3_valid_ff) begin
         corner_ff[s3_slot_ff] <= coord_in;
      end
   end

   assign corners = corner_ff;

endmodule

// ===== sv/kpad_score.sv =====
// ----------------------------------------------------------------------------
// kpad_score: objectness hold and color and class argmax
// keeps the first maximum of each score group over the current anchor
// ----------------------------------------------------------------------------
module kpad_score
   import kpad_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  tag_type                   tag,
   input  logic signed [VALUE_W-1:0] value,
   output score_type                 score
);

   logic signed [VALUE_W-1:0] obj_ff, obj_in;
   logic signed [VALUE_W-1:0] color_score_ff, color_score_in, color_score_cand;
   logic signed [VALUE_W-1:0] class_score_ff, class_score_in, class_score_cand;
   logic [SLOT_W-1:0]         color_index_ff, color_index_in, color_index_cand;
   logic [SLOT_W-1:0]         class_index_ff, class_index_in, class_index_cand;
   logic                      color_take, class_take;

   assign color_take = (tag.kind == KIND_COLOR)
                     && ((tag.slot == '0) || (value > color_score_ff));
   assign class_take = (tag.kind == KIND_CLASS)
                     && ((tag.slot == '0) || (value > class_score_ff));

   assign color_score_cand = color_take ? value : color_score_ff;
   assign color_index_cand = color_take ? tag.slot : color_index_ff;
   assign class_score_cand = class_take ? value : class_score_ff;
   assign class_index_cand = class_take ? tag.slot : class_index_ff;

   assign obj_in         = (load && (tag.kind == KIND_OBJECTNESS)) ? value : obj_ff;
   assign color_score_in = load ? color_score_cand : color_score_ff;
   assign color_index_in = load ? color_index_cand : color_index_ff;
   assign class_score_in = load ? class_score_cand : class_score_ff;
   assign class_index_in = load ? class_index_cand : class_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_index_ff <= '0;
         class_index_ff <= '0;
      end else begin
         color_index_ff <= color_index_in;
         class_index_ff <= class_index_in;
      end
   end

   always_ff @(posedge clock) begin
      obj_ff         <= obj_in;
      color_score_ff <= color_score_in;
      class_score_ff <= class_score_in;
   end

   assign score.color_index = color_index_cand[INDEX_W-1:0];
   assign score.class_index = class_index_cand[INDEX_W-1:0];
   assign score.objectness  = obj_ff;

endmodule

// ===== sv/keypoint_detector_anchor_decode.sv =====
// ----------------------------------------------------------------------------
// keypoint_detector_anchor_decode: anchor decoder for a keypoint detector
// Takes the detector output tensor one value per request on the req_
// channel (valid/ready); every anchor is 9 + COLOR_COUNT + CLASS_COUNT
// values: eight corner coordinates, objectness, color and class scores.
// Corners are decoded to source pixels as they arrive; after an anchor's
// last value a proposal leaves on the rsp_ channel if its objectness is at
// least the threshold. frame_start restarts the anchor walk.
// Throughput: one value per cycle while req_ready is high. A proposal is
// loaded as the last value leaves s0. Corner decode is a four-stage pipeline
// (grid add and shift, two partial products, floor, offset and saturate).
// A single output register holds the proposal; req_ready drops only while
// an anchor's last value that emits waits for that register to be taken.
// The APB port (psel..pready, pready always high) holds inverse_scale,
// offset_x, offset_y and score_threshold at byte addresses 0, 4, 8, 12;
// write them only while no values are in flight (four cycles after the
// last request).
// Reset clears the walk to anchor 0 of stride 8, loads the register reset
// values and drops any held proposal.
// ----------------------------------------------------------------------------
module keypoint_detector_anchor_decode
   import kpad_pkg::*;
#(
   parameter int IMAGE_WIDTH  = 416,
   parameter int IMAGE_HEIGHT = 416,
   parameter int COLOR_COUNT  = 8,
   parameter int CLASS_COUNT  = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic                      accept;
   tag_type                   walk_tag;

   logic                      s0_valid_ff, s0_valid_in;
   logic signed [VALUE_W-1:0] s0_value_ff, s0_value_in;
   tag_type                   s0_tag_ff, s0_tag_in;
   logic                      s0_adv;
   logic                      emit;
   logic                      stall;

   score_type                 score;
   logic [CORNER_VALUES-1:0][VALUE_W-1:0] corners;

   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;
   logic                      rsp_load;

   logic                      csr_write;
   reg_index_type             reg_index;
   logic [SCALE_W-1:0]        inverse_scale_ff, inverse_scale_in;
   logic signed [VALUE_W-1:0] offset_x_ff, offset_x_in;
   logic signed [VALUE_W-1:0] offset_y_ff, offset_y_in;
   logic signed [VALUE_W-1:0] threshold_ff, threshold_in;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_index = reg_index_type'(paddr[3:2]);

   always_comb begin
      inverse_scale_in = inverse_scale_ff;
      offset_x_in      = offset_x_ff;
      offset_y_in      = offset_y_ff;
      threshold_in     = threshold_ff;
      if (csr_write) begin
         case (reg_index)
            REG_INVERSE_SCALE:   inverse_scale_in = pwdata[SCALE_W-1:0];
            REG_OFFSET_X:        offset_x_in      = pwdata;
            REG_OFFSET_Y:        offset_y_in      = pwdata;
            REG_SCORE_THRESHOLD: threshold_in     = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_INVERSE_SCALE:   prdata = {{(CSR_DATA_W - SCALE_W){1'b0}}, inverse_scale_ff};
         REG_OFFSET_X:        prdata = offset_x_ff;
         REG_OFFSET_Y:        prdata = offset_y_ff;
         REG_SCORE_THRESHOLD: prdata = threshold_ff;
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_scale_ff <= INVERSE_SCALE_RESET;
         offset_x_ff      <= OFFSET_X_RESET;
         offset_y_ff      <= OFFSET_Y_RESET;
         threshold_ff     <= SCORE_THRESHOLD_RESET;
      end else begin
         inverse_scale_ff <= inverse_scale_in;
         offset_x_ff      <= offset_x_in;
         offset_y_ff      <= offset_y_in;
         threshold_ff     <= threshold_in;
      end
   end

   // request side
   assign accept    = req_valid && req_ready;
   assign emit      = s0_valid_ff && s0_tag_ff.last && (score.objectness >= threshold_ff);
   assign stall     = emit && rsp_valid_ff && !rsp_ready;
   assign s0_adv    = s0_valid_ff && !stall;
   assign req_ready = !stall;

   kpad_walk #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT),
      .COLOR_COUNT  (COLOR_COUNT),
      .CLASS_COUNT  (CLASS_COUNT)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_data.frame_start),
      .tag         (walk_tag)
   );

   assign s0_valid_in = accept ? 1'b1 : (s0_adv ? 1'b0 : s0_valid_ff);
   assign s0_value_in = accept ? req_data.feature_value : s0_value_ff;
   assign s0_tag_in   = accept ? walk_tag : s0_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_value_ff <= s0_value_in;
      s0_tag_ff   <= s0_tag_in;
   end

   kpad_corner u_corner (
      .clock         (clock),
      .reset         (reset),
      .load          (s0_adv && (s0_tag_ff.kind == KIND_CORNER)),
      .value         (s0_value_ff),
      .tag           (s0_tag_ff),
      .inverse_scale (inverse_scale_ff),
      .offset_x      (offset_x_ff),
      .offset_y      (offset_y_ff),
      .corners       (corners)
   );

   kpad_score u_score (
      .clock (clock),
      .reset (reset),
      .load  (s0_adv),
      .tag   (s0_tag_ff),
      .value (s0_value_ff),
      .score (score)
   );

   // response register
   assign rsp_load = s0_adv && emit;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.corner0_x     = corners[0];
         rsp_data_in.corner0_y     = corners[1];
         rsp_data_in.corner1_x     = corners[2];
         rsp_data_in.corner1_y     = corners[3];
         rsp_data_in.corner2_x     = corners[4];
         rsp_data_in.corner2_y     = corners[5];
         rsp_data_in.corner3_x     = corners[6];
         rsp_data_in.corner3_y     = corners[7];
         rsp_data_in.color_index   = score.color_index;
         rsp_data_in.class_index   = score.class_index;
         rsp_data_in.objectness    = score.objectness;
         rsp_data_in.anchor_number = s0_tag_ff.anchor;
      end
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a held proposal is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !rsp_load)
      else $error("proposal overwritten while held");

   // frame start restarts at the first corner of anchor 0
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.frame_start) |=>
         (s0_tag_ff.kind == KIND_CORNER) && (s0_tag_ff.slot == '0)
         && (s0_tag_ff.anchor == '0) && (s0_tag_ff.level == LEVEL_S8))
      else $error("frame start did not restart the walk");

   // a new proposal only follows an anchor's last value
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s0_valid_ff && s0_tag_ff.last))
      else $error("proposal without an anchor end");
`endif

endmodule
